[sv/asnd_pkg.sv]
// Shared widths, codes and constant tables of the alarm delay finder.
`timescale 1ns / 1ps
package asnd_pkg;

  localparam int OP_W     = 2;
  localparam int TIMER_W  = 4;
  localparam int FIELD_W  = 2;
  localparam int SLOT_W   = 3;
  localparam int ENTRY_W  = 7;
  localparam int LEN_W    = 4;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int WDAY_W   = 3;
  localparam int NOW_W    = 6;
  localparam int DELAY_W  = 20;
  localparam int CHOSEN_W = 4;
  localparam int CFG_W    = 5;

  // Signed width of delays, field minimums and schedule totals.
  localparam int DW = 28;

  localparam logic [OP_W-1:0] OP_WRITE_ENTRY  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_LENGTH = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY        = 2'd2;

  localparam logic [FIELD_W-1:0] FIELD_SECOND  = 2'd0;
  localparam logic [FIELD_W-1:0] FIELD_MINUTE  = 2'd1;
  localparam logic [FIELD_W-1:0] FIELD_HOUR    = 2'd2;
  localparam logic [FIELD_W-1:0] FIELD_WEEKDAY = 2'd3;

  localparam logic [ENTRY_W-1:0] WILDCARD = 7'h7F;

  localparam logic signed [DW-1:0] NO_ALARM     = 28'sd1000000;
  localparam logic [DELAY_W-1:0]   NO_ALARM_OUT = 20'd1000000;

  // Seconds per unit of each field, and the span that a negative delay wraps by.
  localparam logic [16:0] UNIT [4] = '{17'd1, 17'd60, 17'd3600, 17'd86400};
  localparam logic [19:0] WRAP [4] = '{20'd60, 20'd3600, 20'd86400, 20'd604800};

  typedef struct packed {
    logic               clear;
    logic               valid;
    logic [FIELD_W-1:0] field;
    logic               carry;
  } asnd_eval_ctl_t;

  typedef struct packed {
    logic busy;
    logic borrow;
  } asnd_eval_sts_t;

endpackage

[sv/asnd_cmd_if.sv]
// Command channel: element writes, length writes and queries.
`timescale 1ns / 1ps
interface asnd_cmd_if import asnd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic [TIMER_W-1:0]         timer_index;
  logic [FIELD_W-1:0]         field_kind;
  logic [SLOT_W-1:0]          slot;
  logic signed [ENTRY_W-1:0]  entry_value;
  logic [LEN_W-1:0]           list_length;
  logic [SEC_W-1:0]           now_second;
  logic [MIN_W-1:0]           now_minute;
  logic [HOUR_W-1:0]          now_hour;
  logic [WDAY_W-1:0]          now_weekday;

  modport source (
    output valid, op, timer_index, field_kind, slot, entry_value, list_length,
           now_second, now_minute, now_hour, now_weekday,
    input  ready
  );
  modport sink (
    input  valid, op, timer_index, field_kind, slot, entry_value, list_length,
           now_second, now_minute, now_hour, now_weekday,
    output ready
  );
endinterface

[sv/asnd_rsp_if.sv]
// Result channel: delay to the next alarm and the schedule that fires.
`timescale 1ns / 1ps
interface asnd_rsp_if import asnd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DELAY_W-1:0]  delay_seconds;
  logic [CHOSEN_W-1:0] chosen_timer;

  modport source (output valid, delay_seconds, chosen_timer, input ready);
  modport sink (input valid, delay_seconds, chosen_timer, output ready);
endinterface

[sv/asnd_cfg_if.sv]
// Configuration write channel for the active schedule count.
`timescale 1ns / 1ps
interface asnd_cfg_if import asnd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] active_timers;

  modport source (output valid, active_timers, input ready);
  modport sink (input valid, active_timers, output ready);
endinterface

[sv/asnd_field_eval.sv]
// Two-stage delay evaluator that keeps the running minimum of one field list.
`timescale 1ns / 1ps
module asnd_field_eval import asnd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  asnd_eval_ctl_t            ctl,
  input  logic signed [ENTRY_W-1:0] value,
  input  logic [NOW_W-1:0]          now_val,
  output asnd_eval_sts_t            sts,
  output logic signed [DW-1:0]      best
);

  logic signed [9:0]    diff;
  logic signed [17:0]   unit_s;
  logic                 p1_valid;
  logic signed [DW-1:0] p1_prod;
  logic                 p1_wild;
  logic [FIELD_W-1:0]   p1_field;
  logic signed [DW-1:0] d;
  logic                 d_borrow;
  logic                 borrow;

  // Weekday entries count from one, so they lose one more.
  always_comb begin
    diff = 10'(value) - {4'b0, now_val} - {9'b0, ctl.carry}
           - {9'b0, ctl.field == FIELD_WEEKDAY};
    unit_s = {1'b0, UNIT[ctl.field]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= ctl.valid;
    end
    if (ctl.valid) begin
      p1_prod  <= DW'(diff) * DW'(unit_s);
      p1_wild  <= (value == WILDCARD);
      p1_field <= ctl.field;
    end
  end

  always_comb begin
    if (p1_wild) begin
      d        = (p1_field == FIELD_SECOND) ? DW'(1) : '0;
      d_borrow = 1'b0;
    end else if (p1_prod[DW-1]) begin
      d        = p1_prod + DW'(WRAP[p1_field]);
      d_borrow = 1'b1;
    end else begin
      d        = p1_prod;
      d_borrow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      best   <= NO_ALARM;
      borrow <= 1'b0;
    end else if (p1_valid && best > d) begin
      best   <= d;
      borrow <= d_borrow;
    end
  end

  assign sts.busy   = p1_valid;
  assign sts.borrow = borrow;

endmodule

[sv/alarm_schedule_next_delay_core.sv]
// Top level of the weekly alarm next-delay finder.
//
// Usage: the cmd channel takes three kinds of items. An element write stores
// one list entry of a schedule, a length write sets how many entries of a list
// count, and a query carries the current time. Only a query gives a result on
// the rsp channel: the seconds until the earliest schedule fires (at least 1,
// 1000000 when none can fire) and that schedule's index. The cfg channel sets
// the number of schedules in use and is always ready.
// A query walks the list memory one entry per cycle; each field list costs a
// length read, the walk of its entries, the evaluator pipeline drain and the
// field sum. cmd is not ready while a query is in flight.
// Reset clears the control state, the schedule count and the last chosen
// index; the list memories hold no defined contents until written.
// The result sits in an output register; a new query may be taken while it
// waits, and a finished query holds until the receiver has taken the
// previous result.
`timescale 1ns / 1ps
module alarm_schedule_next_delay_core import asnd_pkg::*; #(
  parameter int MAX_TIMERS = 16,
  parameter int LIST_SLOTS = 8
) (
  input  logic     clk,
  input  logic     rst,
  asnd_cmd_if.sink   cmd,
  asnd_cfg_if.sink   cfg,
  asnd_rsp_if.source rsp
);

  localparam int VAL_DEPTH = MAX_TIMERS * 4 * LIST_SLOTS;
  localparam int LEN_DEPTH = MAX_TIMERS * 4;
  localparam int VAW       = $clog2(VAL_DEPTH);
  localparam int LAW       = $clog2(LEN_DEPTH);
  localparam int NW        = $clog2(MAX_TIMERS + 1);
  localparam int SW        = $clog2(LIST_SLOTS + 1);
  localparam int AXW       = 18;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LEN   = 6'b000010,
    S_RUN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_DONE  = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      active_timers;
  logic [SEC_W-1:0]      now_second;
  logic [MIN_W-1:0]      now_minute;
  logic [HOUR_W-1:0]     now_hour;
  logic [WDAY_W-1:0]     now_weekday;
  logic [NW-1:0]         n_act;
  logic [NW-1:0]         timer;
  logic [FIELD_W-1:0]    field;
  logic [SW-1:0]         slot;
  logic                  carry;
  logic signed [DW-1:0]  total;
  logic signed [DW-1:0]  least;
  logic [CHOSEN_W-1:0]   last_chosen;
  logic                  rd_valid;
  logic                  out_valid;
  logic [DELAY_W-1:0]    out_delay;
  logic [CHOSEN_W-1:0]   out_chosen;

  logic [ENTRY_W-1:0]    val_mem [VAL_DEPTH];
  logic [LEN_W-1:0]      len_mem [LEN_DEPTH];
  logic [ENTRY_W-1:0]    val_rdata;
  logic [LEN_W-1:0]      len_rdata;

  logic                  cmd_acc;
  logic                  val_we;
  logic                  len_we;
  logic                  rd_en;
  logic                  len_re;
  logic [AXW-1:0]        wr_vaddr;
  logic [AXW-1:0]        wr_laddr;
  logic [AXW-1:0]        rd_vaddr;
  logic [AXW-1:0]        rd_laddr;
  logic [NW-1:0]         act_sat;
  logic [SW-1:0]         n_elems;
  logic [NOW_W-1:0]      now_sel;
  logic signed [DW-1:0]  field_total;
  logic                  out_free;
  logic                  last_timer;

  asnd_eval_ctl_t        ev_ctl;
  asnd_eval_sts_t        ev_sts;
  logic signed [DW-1:0]  ev_best;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid         = out_valid;
  assign rsp.delay_seconds = out_delay;
  assign rsp.chosen_timer  = out_chosen;

  always_comb begin
    wr_laddr = AXW'(cmd.timer_index) * AXW'(4) + AXW'(cmd.field_kind);
    wr_vaddr = wr_laddr * AXW'(LIST_SLOTS) + AXW'(cmd.slot);
    rd_laddr = AXW'(timer) * AXW'(4) + AXW'(field);
    rd_vaddr = rd_laddr * AXW'(LIST_SLOTS) + AXW'(slot);

    val_we = cmd_acc && (cmd.op == OP_WRITE_ENTRY)
             && ({5'b0, cmd.timer_index} < 9'(MAX_TIMERS))
             && ({4'b0, cmd.slot} < 7'(LIST_SLOTS));
    len_we = cmd_acc && (cmd.op == OP_WRITE_LENGTH)
             && ({5'b0, cmd.timer_index} < 9'(MAX_TIMERS));

    if ({4'b0, active_timers} > 9'(MAX_TIMERS)) begin
      act_sat = NW'(MAX_TIMERS);
    end else begin
      act_sat = NW'(active_timers);
    end

    // A stored length above the list size saturates to the list size.
    if ({3'b0, len_rdata} > 7'(LIST_SLOTS)) begin
      n_elems = SW'(LIST_SLOTS);
    end else begin
      n_elems = SW'(len_rdata);
    end

    case (field)
      FIELD_SECOND:  now_sel = now_second;
      FIELD_MINUTE:  now_sel = now_minute;
      FIELD_HOUR:    now_sel = NOW_W'(now_hour);
      FIELD_WEEKDAY: now_sel = NOW_W'(now_weekday);
      default:       now_sel = now_second;
    endcase

    len_re      = (state == S_LEN);
    rd_en       = (state == S_RUN) && (slot < n_elems);
    field_total = total + ev_best;
    last_timer  = (NW'(timer + 1'b1) == n_act);
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_vaddr[VAW-1:0]] <= cmd.entry_value;
    end
    if (rd_en) begin
      val_rdata <= val_mem[rd_vaddr[VAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_laddr[LAW-1:0]] <= cmd.list_length;
    end
    if (len_re) begin
      len_rdata <= len_mem[rd_laddr[LAW-1:0]];
    end
  end

  assign ev_ctl.clear = len_re;
  assign ev_ctl.valid = rd_valid;
  assign ev_ctl.field = field;
  assign ev_ctl.carry = carry;

  asnd_field_eval u_eval (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ev_ctl),
    .value   (val_rdata),
    .now_val (now_sel),
    .sts     (ev_sts),
    .best    (ev_best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_timers <= '0;
      last_chosen   <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
      timer         <= '0;
      field         <= FIELD_SECOND;
      slot          <= '0;
      carry         <= 1'b0;
      n_act         <= '0;
      total         <= '0;
      least         <= NO_ALARM;
    end else begin
      rd_valid <= rd_en;
      if (cfg.valid) begin
        active_timers <= cfg.active_timers;
      end
      // In the result hand-off the register is reloaded instead.
      if (out_valid && rsp.ready && state != S_WAIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc && cmd.op == OP_QUERY) begin
            now_second  <= cmd.now_second;
            now_minute  <= cmd.now_minute;
            now_hour    <= cmd.now_hour;
            now_weekday <= cmd.now_weekday;
            n_act       <= act_sat;
            timer       <= '0;
            field       <= FIELD_SECOND;
            carry       <= 1'b0;
            total       <= '0;
            least       <= NO_ALARM;
            state       <= (act_sat == '0) ? S_DONE : S_LEN;
          end
        end
        S_LEN: begin
          slot  <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (rd_en) begin
            slot <= slot + 1'b1;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The field minimum is final once no read or product is in flight.
          if (!rd_valid && !ev_sts.busy) begin
            if (field == FIELD_WEEKDAY) begin
              if (least > field_total) begin
                least       <= field_total;
                last_chosen <= CHOSEN_W'(timer);
              end
              total <= '0;
              carry <= 1'b0;
              field <= FIELD_SECOND;
              if (last_timer) begin
                state <= S_DONE;
              end else begin
                timer <= timer + 1'b1;
                state <= S_LEN;
              end
            end else begin
              total <= field_total;
              carry <= ev_sts.borrow;
              field <= field + 1'b1;
              state <= S_LEN;
            end
          end
        end
        S_DONE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload of the result register; loaded only when the previous item is gone.
  always_ff @(posedge clk) begin
    if (state == S_WAIT && out_free) begin
      if (least[DW-1] || least == '0) begin
        out_delay <= DELAY_W'(1);
      end else begin
        out_delay <= least[DELAY_W-1:0];
      end
      out_chosen <= last_chosen;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    ev_sts.busy |-> (state == S_RUN || state == S_DRAIN))
    else $error("evaluator busy outside a list walk");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.delay_seconds != '0 && rsp.delay_seconds <= NO_ALARM_OUT))
    else $error("result delay out of range");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (9'(rsp.chosen_timer) < 9'(MAX_TIMERS)))
    else $error("chosen schedule beyond the table");

  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_WAIT))
    else $error("result raised outside the result hand-off");
`endif

endmodule
